// ===== hw/rtl/decision_tree_classifier_assert.svh =====
// Assertion macros used by the decision tree classifier controller.
`ifndef DECISION_TREE_CLASSIFIER_ASSERT_SVH
`define DECISION_TREE_CLASSIFIER_ASSERT_SVH

// Checked at every rising edge of clk, and not checked while reset is held.
`define DTC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising edge of clk, during reset as well.
`define DTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/dtc_pkg.sv =====
// Shared constants, types and control structs of the decision tree classifier.
`default_nettype none

package dtc_pkg;

  // Table sizes and value format.
  localparam int NODE_COUNT    = 256;
  localparam int NODE_W        = $clog2(NODE_COUNT);
  localparam int FEATURE_COUNT = 64;
  localparam int FEAT_W        = $clog2(FEATURE_COUNT);
  localparam int VALUE_W       = 32;
  localparam int STEP_W        = 9;

  // Step count of the last inner node before the walk is stopped.
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(NODE_COUNT - 1);
  localparam logic [STEP_W-1:0] STEP_LIMIT = STEP_W'(NODE_COUNT);

  // Request command codes.
  typedef enum logic [1:0] {
    CMD_LOAD_NODE = 2'd0,
    CMD_LOAD_FEAT = 2'd1,
    CMD_CLASSIFY  = 2'd2,
    CMD_UNUSED    = 2'd3
  } command_t;

  // One node table entry.
  typedef struct packed {
    logic [7:0]                split;
    logic signed [VALUE_W-1:0] thr;
    logic [7:0]                left;
    logic [7:0]                right;
  } node_entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_node;
    logic load_feat;
    logic start;
    logic feat_rd;
    logic advance;
    logic res_load;
    logic res_err;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_leaf;
    logic last_step;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dtc_datapath.sv =====
// Datapath of the decision tree classifier: node and feature memories,
// threshold compare, step counter and result register.
`default_nettype none

module dtc_datapath (
  input  wire logic                            clk,
  input  wire dtc_pkg::dp_cmd_t                cmd,
  output dtc_pkg::dp_status_t                  status,
  input  wire logic [7:0]                      in_node_index,
  input  wire logic [7:0]                      in_split_or_class,
  input  wire logic signed [dtc_pkg::VALUE_W-1:0] in_threshold,
  input  wire logic [7:0]                      in_left_child,
  input  wire logic [7:0]                      in_right_child,
  input  wire logic [5:0]                      in_feature_index,
  input  wire logic signed [dtc_pkg::VALUE_W-1:0] in_feature_value,
  output logic [7:0]                           out_predicted_class,
  output logic                                 out_walk_error,
  output logic [8:0]                           out_depth_used
);
  import dtc_pkg::*;

  node_entry_t               node_mem [NODE_COUNT];
  logic signed [VALUE_W-1:0] feat_mem [FEATURE_COUNT];

  node_entry_t               node_q_r;
  logic signed [VALUE_W-1:0] feat_q_r;
  logic [STEP_W-1:0]         steps_r;
  logic [7:0]                class_r;
  logic                      err_r;
  logic [STEP_W-1:0]         depth_r;

  node_entry_t               wr_entry;
  logic                      go_left;
  logic [7:0]                next_child;
  logic [NODE_W-1:0]         rd_addr;
  logic                      node_rd;

  // Entry built from the load request.
  always_comb begin
    wr_entry.split = in_split_or_class;
    wr_entry.thr   = in_threshold;
    wr_entry.left  = in_left_child;
    wr_entry.right = in_right_child;
  end

  // Signed compare of the selected feature against the node threshold.
  assign go_left    = feat_q_r < node_q_r.thr;
  assign next_child = go_left ? node_q_r.left : node_q_r.right;

  // The walk starts at the root and then follows the chosen child.
  assign node_rd = cmd.start | cmd.advance;
  assign rd_addr = cmd.start ? '0 : next_child[NODE_W-1:0];

  // Node memory: one write port for loads, one registered read port for the walk.
  always_ff @(posedge clk) begin
    if (cmd.load_node) begin
      node_mem[in_node_index[NODE_W-1:0]] <= wr_entry;
    end
    if (node_rd) begin
      node_q_r <= node_mem[rd_addr];
    end
  end

  // Feature memory: written by loads, read at the split feature of the current node.
  always_ff @(posedge clk) begin
    if (cmd.load_feat) begin
      feat_mem[in_feature_index[FEAT_W-1:0]] <= in_feature_value;
    end
    if (cmd.feat_rd) begin
      feat_q_r <= feat_mem[node_q_r.split[FEAT_W-1:0]];
    end
  end

  // Count of inner nodes passed on this walk.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      steps_r <= '0;
    end else if (cmd.advance) begin
      steps_r <= steps_r + STEP_W'(1);
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      if (cmd.res_err) begin
        class_r <= '0;
        err_r   <= 1'b1;
        depth_r <= STEP_LIMIT;
      end else begin
        class_r <= node_q_r.split;
        err_r   <= 1'b0;
        depth_r <= steps_r;
      end
    end
  end

  assign status.is_leaf   = (node_q_r.left == 8'd0);
  assign status.last_step = (steps_r == LAST_STEP);

  assign out_predicted_class = class_r;
  assign out_walk_error      = err_r;
  assign out_depth_used      = depth_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dtc_ctrl.sv =====
// Controller of the decision tree classifier: request handshake, walk
// sequencing and result valid.
`default_nettype none

module dtc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_command,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output dtc_pkg::dp_cmd_t          cmd,
  input  wire dtc_pkg::dp_status_t  status
);
  import dtc_pkg::*;

  `include "decision_tree_classifier_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_CMP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_accept;

  // A classify request waits until the previous result has been taken.
  assign in_stall  = (state_r != S_IDLE) ||
                     (out_valid_r && (in_command == CMD_CLASSIFY));
  assign in_accept = in_valid && !in_stall;

  // Walk sequencing: read a node, then read its feature and pick the child.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_command)
            CMD_LOAD_NODE: cmd.load_node = 1'b1;
            CMD_LOAD_FEAT: cmd.load_feat = 1'b1;
            CMD_CLASSIFY: begin
              cmd.start = 1'b1;
              state_nxt = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (status.is_leaf) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.feat_rd = 1'b1;
          state_nxt   = S_CMP;
        end
      end
      S_CMP: begin
        cmd.advance = 1'b1;
        if (status.last_step) begin
          cmd.res_load = 1'b1;
          cmd.res_err  = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_CHECK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set when a walk ends, cleared when the result is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // A new result never overwrites one that is still waiting.
  `DTC_ASSERT(a_no_overwrite, cmd.res_load |-> !out_valid_r, "result overwritten")
  // An accepted classify request starts a walk at the root.
  `DTC_ASSERT(a_walk_start, (in_accept && (in_command == CMD_CLASSIFY)) |=> (state_r == S_CHECK), "walk did not start")
  // The compare step always follows a node check.
  `DTC_ASSERT(a_cmp_order, (state_r == S_CMP) |-> ($past(state_r) == S_CHECK), "compare without node check")
  // A walk that reaches the step limit ends with a valid error result.
  `DTC_ASSERT(a_step_limit, ((state_r == S_CMP) && status.last_step) |=> ((state_r == S_IDLE) && out_valid_r), "step limit not enforced")

endmodule

`default_nettype wire

// ===== hw/rtl/decision_tree_classifier.sv =====
// Top level of the decision tree classifier.
//
//   channel   direction  handshake         payload
//   in_       input      in_valid/in_stall   command, node and feature fields
//   out_      output     out_valid/out_stall predicted_class, walk_error, depth_used
//
// A classify request walks from the root to a leaf reached after d inner nodes:
// each level costs one node memory read and one feature memory read followed by
// the compare.
// A walk is stopped after 256 inner nodes and reports an error.
// Reset is synchronous and active low; it clears only control state, the
// memories hold whatever was written.
// A waiting result stalls classify requests only; loads are still taken.
`default_nettype none

module decision_tree_classifier (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_command,
  input  wire logic [7:0]                         in_node_index,
  input  wire logic [7:0]                         in_split_or_class,
  input  wire logic signed [dtc_pkg::VALUE_W-1:0] in_threshold,
  input  wire logic [7:0]                         in_left_child,
  input  wire logic [7:0]                         in_right_child,
  input  wire logic [5:0]                         in_feature_index,
  input  wire logic signed [dtc_pkg::VALUE_W-1:0] in_feature_value,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [7:0]                              out_predicted_class,
  output logic                                    out_walk_error,
  output logic [8:0]                              out_depth_used
);
  import dtc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencer and handshake.
  dtc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_command (in_command),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .status     (status)
  );

  // Memories, compare and result register.
  dtc_datapath u_datapath (
    .clk                 (clk),
    .cmd                 (cmd),
    .status              (status),
    .in_node_index       (in_node_index),
    .in_split_or_class   (in_split_or_class),
    .in_threshold        (in_threshold),
    .in_left_child       (in_left_child),
    .in_right_child      (in_right_child),
    .in_feature_index    (in_feature_index),
    .in_feature_value    (in_feature_value),
    .out_predicted_class (out_predicted_class),
    .out_walk_error      (out_walk_error),
    .out_depth_used      (out_depth_used)
  );

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the decision tree classifier: scoreboard class, drivers and monitor.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dtc_pkg::*;

  localparam int REQ_GOAL     = 1600;
  localparam int DRAIN_CYCLES = 600;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AT      = 600;
  localparam int CALM_LO      = 200;
  localparam int CALM_HI      = 400;
  localparam int MAX_REPORTS  = 10;

  typedef bit signed [VALUE_W-1:0] value_t;

  // One request as offered on the input channel.
  typedef struct {
    command_t      cmd;
    bit [7:0]      node;
    bit [7:0]      split;
    value_t        thr;
    bit [7:0]      left;
    bit [7:0]      right;
    bit [FEAT_W-1:0] fidx;
    value_t        fval;
  } tree_req_t;

  // One classification outcome.
  typedef struct packed {
    logic [7:0]        cls;
    logic              err;
    logic [STEP_W-1:0] depth;
  } verdict_t;

  // Mirror of the node table and sample, plus the queue of outcomes still owed.
  class tree_scoreboard;
    bit [7:0]  split_tab[NODE_COUNT];
    value_t    thr_tab[NODE_COUNT];
    bit [7:0]  left_tab[NODE_COUNT];
    bit [7:0]  right_tab[NODE_COUNT];
    bit        node_set[NODE_COUNT];
    value_t    feat_tab[FEATURE_COUNT];
    bit        feat_set[FEATURE_COUNT];
    verdict_t  owed[$];
    int        mismatches;
    int        checked;
    int        classified;
    int        stopped;
    int        deepest;

    // Walks the mirrored tree; returns 0 if the walk touched an entry never loaded.
    function bit walk(output verdict_t v);
      bit [NODE_W-1:0] node;
      bit [FEAT_W-1:0] f;
      int              steps;
      bit              ok;
      node = '0;
      steps = 0;
      ok = 1'b1;
      v.cls = 8'd0;
      v.err = 1'b1;
      v.depth = STEP_LIMIT;
      while (steps < NODE_COUNT) begin
        if (!node_set[node]) ok = 1'b0;
        if (left_tab[node] == 8'd0) begin
          v.cls = split_tab[node];
          v.err = 1'b0;
          v.depth = STEP_W'(steps);
          return ok;
        end
        f = split_tab[node][FEAT_W-1:0];
        if (!feat_set[f]) ok = 1'b0;
        node = (feat_tab[f] < thr_tab[node]) ? left_tab[node] : right_tab[node];
        steps++;
      end
      return ok;
    endfunction

    // Applies an accepted request to the mirror.
    function void note(tree_req_t r);
      verdict_t v;
      case (r.cmd)
        CMD_LOAD_NODE: begin
          split_tab[r.node] = r.split;
          thr_tab[r.node]   = r.thr;
          left_tab[r.node]  = r.left;
          right_tab[r.node] = r.right;
          node_set[r.node]  = 1'b1;
        end
        CMD_LOAD_FEAT: begin
          feat_tab[r.fidx] = r.fval;
          feat_set[r.fidx] = 1'b1;
        end
        CMD_CLASSIFY: begin
          void'(walk(v));
          owed.insert(owed.size(), v);
          classified++;
          if (v.err) stopped++;
          else if (int'(v.depth) > deepest) deepest = int'(v.depth);
        end
        default: ;
      endcase
    endfunction

    // Compares a delivered outcome with the oldest one owed.
    function void check(verdict_t got);
      verdict_t want;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing outstanding: class %0d err %0b depth %0d",
                   $realtime, got.cls, got.err, got.depth);
        return;
      end
      want = owed.pop_front();
      checked++;
      if (got.cls !== want.cls || got.err !== want.err || got.depth !== want.depth) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch: expected class %0d err %0b depth %0d, got %0d %0b %0d",
                   $realtime, want.cls, want.err, want.depth, got.cls, got.err, got.depth);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [1:0]          in_command;
  logic [7:0]          in_node_index;
  logic [7:0]          in_split_or_class;
  logic signed [VALUE_W-1:0] in_threshold;
  logic [7:0]          in_left_child;
  logic [7:0]          in_right_child;
  logic [5:0]          in_feature_index;
  logic signed [VALUE_W-1:0] in_feature_value;
  logic                out_valid;
  logic                out_stall;
  logic [7:0]          out_predicted_class;
  logic                out_walk_error;
  logic [8:0]          out_depth_used;

  tree_scoreboard board = new();
  int             taken_reqs = 0;
  bit             id_busy[NODE_COUNT];

  decision_tree_classifier uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_command          (in_command),
    .in_node_index       (in_node_index),
    .in_split_or_class   (in_split_or_class),
    .in_threshold        (in_threshold),
    .in_left_child       (in_left_child),
    .in_right_child      (in_right_child),
    .in_feature_index    (in_feature_index),
    .in_feature_value    (in_feature_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_predicted_class (out_predicted_class),
    .out_walk_error      (out_walk_error),
    .out_depth_used      (out_depth_used)
  );

  always #5 clk = ~clk;

  // Both sides stop idling while the request count is inside this window.
  function automatic bit calm_window();
    return taken_reqs >= CALM_LO && taken_reqs < CALM_HI;
  endfunction

  // Random value with the range ends and small values weighted in.
  function automatic value_t pick_value();
    case ($urandom_range(15))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return 32'sd1;
      default: return value_t'($urandom);
    endcase
  endfunction

  // Value on or right next to a threshold, or now and then any value, so both branches and equality get hit.
  function automatic value_t near_value(value_t p);
    case ($urandom_range(3))
      0: return p;
      1: return p - 1;
      2: return p + 1;
      default: return pick_value();
    endcase
  endfunction

  // Request with every field random; callers overwrite the fields that matter.
  function automatic tree_req_t noise_req(command_t c);
    tree_req_t r;
    r.cmd   = c;
    r.node  = 8'($urandom);
    r.split = 8'($urandom);
    r.thr   = value_t'($urandom);
    r.left  = 8'($urandom);
    r.right = 8'($urandom);
    r.fidx  = FEAT_W'($urandom);
    r.fval  = value_t'($urandom);
    return r;
  endfunction

  function automatic bit [7:0] fresh_id();
    bit [7:0] id;
    do id = 8'($urandom_range(1, NODE_COUNT - 1)); while (id_busy[id]);
    id_busy[id] = 1'b1;
    return id;
  endfunction

  // Offers one request, with a random gap first, and holds it until taken.
  task automatic push_req(tree_req_t r);
    int gap;
    gap = 0;
    if (!calm_window())
      while (gap < 8 && $urandom_range(99) < 25) gap++;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_command        <= r.cmd;
    in_node_index     <= r.node;
    in_split_or_class <= r.split;
    in_threshold      <= r.thr;
    in_left_child     <= r.left;
    in_right_child    <= r.right;
    in_feature_index  <= r.fidx;
    in_feature_value  <= r.fval;
    do @(posedge clk); while (in_stall);
    board.note(r);
    if (r.cmd != CMD_UNUSED) taken_reqs++;
  endtask

  task automatic put_node(bit [7:0] idx, bit [7:0] sc, value_t thr, bit [7:0] l, bit [7:0] r);
    tree_req_t q;
    q = noise_req(CMD_LOAD_NODE);
    q.node  = idx;
    q.split = sc;
    q.thr   = thr;
    q.left  = l;
    q.right = r;
    push_req(q);
  endtask

  task automatic put_feature(bit [FEAT_W-1:0] idx, value_t v);
    tree_req_t q;
    q = noise_req(CMD_LOAD_FEAT);
    q.fidx = idx;
    q.fval = v;
    push_req(q);
  endtask

  // Classifies only when the walk stays on loaded entries.
  task automatic try_classify();
    verdict_t v;
    if (board.walk(v)) push_req(noise_req(CMD_CLASSIFY));
  endtask

  // Loads a fresh random tree rooted at node 0 and classifies it a few times.
  task automatic grow_tree(int inner);
    bit [7:0]        open_ids[$];
    bit              need[FEATURE_COUNT];
    value_t          probe[FEATURE_COUNT];
    bit [7:0]        id;
    bit [7:0]        l;
    bit [7:0]        r;
    bit [7:0]        sc;
    bit [FEAT_W-1:0] f;
    value_t          thr;
    int              made;
    id_busy = '{default: 1'b0};
    need = '{default: 1'b0};
    id_busy[0] = 1'b1;
    open_ids.insert(open_ids.size(), 8'd0);
    made = 0;
    while (open_ids.size() > 0) begin
      id = open_ids.pop_front();
      thr = pick_value();
      if (made < inner) begin
        l = fresh_id();
        r = fresh_id();
        sc = 8'($urandom);
        need[sc[FEAT_W-1:0]] = 1'b1;
        probe[sc[FEAT_W-1:0]] = thr;
        put_node(id, sc, thr, l, r);
        open_ids.insert(open_ids.size(), l);
        open_ids.insert(open_ids.size(), r);
        made++;
      end else begin
        put_node(id, 8'($urandom), thr, 8'd0, 8'($urandom));
      end
    end
    for (int i = 0; i < FEATURE_COUNT; i++)
      if (need[i]) put_feature(FEAT_W'(i), near_value(probe[i]));
    // Same tree, new samples: rewrite a few features between classifications.
    repeat ($urandom_range(1, 6)) begin
      try_classify();
      repeat ($urandom_range(0, 3)) begin
        f = FEAT_W'($urandom);
        put_feature(f, need[f] ? near_value(probe[f]) : pick_value());
      end
    end
    try_classify();
  endtask

  // Unstructured loads, ignored commands and classifications.
  task automatic scramble();
    tree_req_t q;
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(3))
        0: begin
          q = noise_req(CMD_LOAD_NODE);
          if ($urandom_range(1)) q.left = 8'd0;
          push_req(q);
        end
        1: put_feature(FEAT_W'($urandom), pick_value());
        2: push_req(noise_req(CMD_UNUSED));
        default: try_classify();
      endcase
    end
    try_classify();
  endtask

  // Fills the whole table as one chain for the deepest walk, then closes it into a loop.
  task automatic run_chain();
    for (int i = 0; i < FEATURE_COUNT; i++) put_feature(FEAT_W'(i), pick_value());
    for (int i = 0; i < NODE_COUNT - 1; i++) begin
      put_node(8'(i), 8'($urandom), pick_value(), 8'(i + 1), 8'(i + 1));
    end
    put_node(8'(NODE_COUNT - 1), 8'($urandom), pick_value(), 8'd0, 8'($urandom));
    try_classify();
    put_node(8'(NODE_COUNT - 1), 8'($urandom), pick_value(),
             8'($urandom_range(1, NODE_COUNT - 1)), 8'd0);
    try_classify();
  endtask

  // Result monitor: sample at the rising edge and check every taken result.
  always @(posedge clk) begin : result_monitor
    verdict_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.cls   = out_predicted_class;
      seen.err   = out_walk_error;
      seen.depth = out_depth_used;
      board.check(seen);
    end
  end

  // Result side: random stalls, a calm window, and one long hold-off.
  initial begin : result_sink
    int  hold;
    bit  held;
    hold = 0;
    held = 1'b0;
    out_stall = 1'b0;
    while (rst_n !== 1'b1) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && taken_reqs >= HOLD_AT) begin
        held = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else if (calm_window()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  // Main stimulus: reset, directed cases, random trees, drain and verdict.
  initial begin : stimulus
    bit chain_done;
    int sel;
    int fails;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_UNUSED;
    in_node_index = '0;
    in_split_or_class = '0;
    in_threshold = '0;
    in_left_child = '0;
    in_right_child = '0;
    in_feature_index = '0;
    in_feature_value = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Root alone as a leaf with the top class label.
    put_node(8'd0, 8'hFF, 32'sh7fffffff, 8'd0, 8'hFF);
    try_classify();
    // One split on the highest feature slot, reached through a wrapped split index.
    put_feature(6'd63, 32'sh7fffffff);
    put_feature(6'd0, 32'sh80000000);
    put_node(8'd1, 8'h00, 32'sd0, 8'd0, 8'd0);
    put_node(8'd2, 8'hAA, 32'sh80000000, 8'd0, 8'h55);
    put_node(8'd0, 8'd127, 32'sh7fffffff, 8'd1, 8'd2);
    try_classify();
    put_feature(6'd63, 32'sh7ffffffe);
    try_classify();
    // Feature equal to the most negative threshold goes right.
    put_node(8'd0, 8'd64, 32'sh80000000, 8'd1, 8'd2);
    try_classify();
    push_req(noise_req(CMD_UNUSED));
    // Self loop below the root: the walk is stopped and flagged.
    put_node(8'd1, 8'd0, 32'sd0, 8'd1, 8'd1);
    put_node(8'd0, 8'd0, 32'sh7fffffff, 8'd1, 8'd1);
    try_classify();
    // Right child 0 leads back to the root.
    put_node(8'd2, 8'h55, 32'sd1, 8'd0, 8'd0);
    put_node(8'd0, 8'd0, 32'sd0, 8'd2, 8'd0);
    try_classify();
    put_feature(6'd0, 32'sd0);
    try_classify();

    // Random part: mostly complete trees, some noise, one full-depth chain.
    chain_done = 1'b0;
    while (taken_reqs < REQ_GOAL) begin
      if (!chain_done && taken_reqs >= 900) begin
        run_chain();
        chain_done = 1'b1;
      end else begin
        sel = $urandom_range(99);
        if (sel < 75) grow_tree($urandom_range(1, 12));
        else scramble();
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    fails = board.mismatches + board.owed.size();
    $display("Sent %0d requests; %0d classifications, %0d stopped on a loop.",
             taken_reqs, board.classified, board.stopped);
    $display("Deepest completed walk passed %0d inner nodes; %0d results checked.",
             board.deepest, board.checked);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin : watchdog
    #40_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
